>>> design/qepid_pkg.sv
`default_nettype none

package qepid_pkg;

  // Widths of the shared multiplier, of the sum of the control terms, of the integral and of the error.
  localparam int unsigned MulAW  = 33;
  localparam int unsigned MulBW  = 25;
  localparam int unsigned ProdW  = MulAW + MulBW;
  localparam int unsigned AccW   = 96;
  localparam int unsigned IntW   = 48;
  localparam int unsigned ErrW   = 25;

  localparam logic       CMD_EDGE = 1'b0;
  localparam logic       CMD_TICK = 1'b1;
  localparam logic       PIN_A    = 1'b0;
  localparam logic       PIN_B    = 1'b1;

  localparam logic [1:0] MODE_X1  = 2'd0;
  localparam logic [1:0] MODE_X2  = 2'd1;
  localparam logic [1:0] MODE_X4  = 2'd2;

  localparam logic [1:0]  RST_COUNT_MODE  = 2'd2;
  localparam logic [23:0] RST_COUNT_SCALE = 24'd77672;
  localparam logic [31:0] RST_GAIN_P      = 32'd65536000;
  localparam logic [31:0] RST_GAIN_I      = 32'd655;
  localparam logic [31:0] RST_GAIN_D      = 32'd262144;
  localparam logic [23:0] RST_TICK_PERIOD = 24'd16777;
  localparam logic [15:0] RST_TICK_RATE   = 16'd1000;
  localparam logic [7:0]  RST_DUTY_LIMIT  = 8'd100;

  localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] POS_MIN = 24'sh800000;

  typedef enum logic [2:0] {
    REG_COUNT_MODE  = 3'd0,
    REG_COUNT_SCALE = 3'd1,
    REG_GAIN_P      = 3'd2,
    REG_GAIN_I      = 3'd3,
    REG_GAIN_D      = 3'd4,
    REG_TICK_PERIOD = 3'd5,
    REG_TICK_RATE   = 3'd6,
    REG_DUTY_LIMIT  = 3'd7
  } reg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POS,
    S_ERR,
    S_MUL_P,
    S_MUL_IL,
    S_MUL_IH,
    S_MUL_DL,
    S_MUL_DH,
    S_MUL_INT,
    S_MUL_DER,
    S_FIN
  } seq_state_t;

  typedef struct packed {
    logic               cmd;
    logic               edge_pin;
    logic               level_a;
    logic               level_b;
    logic signed [23:0] ref_position;
  } item_t;

  typedef struct packed {
    logic signed [31:0] count;
    logic signed [23:0] position;
    logic [7:0]         duty;
    logic               direction;
    logic               is_tick;
  } result_t;

  typedef struct packed {
    logic                     en;
    logic signed [MulAW-1:0]  a;
    logic signed [MulBW-1:0]  b;
  } mul_op_t;

endpackage

`default_nettype wire

>>> design/qepid_mul.sv
`default_nettype none

module qepid_mul
  import qepid_pkg::*;
(
  input  wire                     clk,
  input  mul_op_t                 op,
  output logic signed [ProdW-1:0] prod
);

  logic signed [MulAW-1:0] a_s;
  logic signed [MulBW-1:0] b_s;

  assign a_s = op.a;
  assign b_s = op.b;

  // Signed product, registered; it holds when no operation is issued.
  always_ff @(posedge clk) begin
    if (op.en) begin
      prod <= ProdW'(a_s) * ProdW'(b_s);
    end
  end

endmodule

`default_nettype wire

>>> design/quadrature_encoder_pid_position_control_core.sv
`default_nettype none

// Channel   Valid / ready             Payload     Direction
// item      item_valid / item_ready   item_t      in
// result    result_valid/result_ready result_t    out
// config    psel, penable / pready    pwdata      in (APB write), prdata out
//
// An edge beat goes from the position and error steps to the last step; a tick
// beat runs the term and update multiplies between, and is long because the
// one shared 33x25 multiplier serves each partial product in turn.
// A new beat is accepted once the sequencer is idle, even while the previous
// result still waits in the output register; a full, stalled register holds
// the sequencer in its last step. Reset is synchronous and restores defaults.

module quadrature_encoder_pid_position_control_core
  import qepid_pkg::*;
(
  input  wire         clk,
  input  wire         rst,

  input  wire         item_valid,
  output logic        item_ready,
  input  item_t       item,

  output logic        result_valid,
  input  wire         result_ready,
  output result_t     result,

  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic [1:0]  count_mode;
  logic [23:0] count_scale;
  logic [31:0] gain_p;
  logic [31:0] gain_i;
  logic [31:0] gain_d;
  logic [23:0] tick_period;
  logic [15:0] tick_rate;
  logic [7:0]  duty_limit;

  reg_index_t reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      count_mode  <= RST_COUNT_MODE;
      count_scale <= RST_COUNT_SCALE;
      gain_p      <= RST_GAIN_P;
      gain_i      <= RST_GAIN_I;
      gain_d      <= RST_GAIN_D;
      tick_period <= RST_TICK_PERIOD;
      tick_rate   <= RST_TICK_RATE;
      duty_limit  <= RST_DUTY_LIMIT;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_COUNT_MODE:  count_mode  <= pwdata[1:0];
        REG_COUNT_SCALE: count_scale <= pwdata[23:0];
        REG_GAIN_P:      gain_p      <= pwdata;
        REG_GAIN_I:      gain_i      <= pwdata;
        REG_GAIN_D:      gain_d      <= pwdata;
        REG_TICK_PERIOD: tick_period <= pwdata[23:0];
        REG_TICK_RATE:   tick_rate   <= pwdata[15:0];
        REG_DUTY_LIMIT:  duty_limit  <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_COUNT_MODE:  prdata = {30'd0, count_mode};
      REG_COUNT_SCALE: prdata = {8'd0, count_scale};
      REG_GAIN_P:      prdata = gain_p;
      REG_GAIN_I:      prdata = gain_i;
      REG_GAIN_D:      prdata = gain_d;
      REG_TICK_PERIOD: prdata = {8'd0, tick_period};
      REG_TICK_RATE:   prdata = {16'd0, tick_rate};
      REG_DUTY_LIMIT:  prdata = {24'd0, duty_limit};
    endcase
  end

  // Controller state and working registers.
  seq_state_t state, state_next;

  logic signed [31:0]     enc_count;
  logic signed [IntW-1:0] integral_acc;
  logic signed [ErrW-1:0] previous_error;
  logic signed [IntW-1:0] derivative_term;

  logic                   is_tick;
  logic signed [23:0]     ref_pos;
  logic signed [23:0]     pos;
  logic signed [ErrW-1:0] err;
  logic signed [AccW-1:0] acc;

  logic signed [ProdW-1:0] prod;
  mul_op_t                 mul_op;

  qepid_mul u_mul (
    .clk  (clk),
    .op   (mul_op),
    .prod (prod)
  );

  assign item_ready = (state == S_IDLE);

  // Edge decoding: the mode picks which edges count, the levels pick the way.
  logic edge_used;
  logic edge_up;

  always_comb begin
    unique case (count_mode)
      MODE_X1: edge_used = (item.edge_pin == PIN_A) && item.level_a;
      MODE_X2: edge_used = (item.edge_pin == PIN_A);
      MODE_X4: edge_used = 1'b1;
      default: edge_used = 1'b0;
    endcase
    edge_up = (item.edge_pin == PIN_A) ? (item.level_a != item.level_b)
                                       : (item.level_a == item.level_b);
  end

  // Position is the product shifted down by eight, saturated to 24 bits.
  logic signed [23:0]     pos_sat;
  logic signed [ErrW-1:0] err_next;

  always_comb begin
    if ((&prod[ProdW-1:31]) || !(|prod[ProdW-1:31])) begin
      pos_sat = prod[31:8];
    end else begin
      pos_sat = prod[ProdW-1] ? POS_MIN : POS_MAX;
    end
    err_next = ErrW'(ref_pos) - ErrW'(pos_sat);
  end

  logic signed [ErrW:0] err_sum;
  logic signed [ErrW:0] err_diff;

  assign err_sum  = (ErrW+1)'(err) + (ErrW+1)'(previous_error);
  assign err_diff = (ErrW+1)'(err) - (ErrW+1)'(previous_error);

  // The integral step is the product shifted down by nine; it saturates.
  logic signed [IntW:0] int_sum;
  logic signed [IntW-1:0] int_sat;

  assign int_sum = (IntW+1)'(integral_acc) + prod[ProdW-1:9];

  always_comb begin
    if (int_sum[IntW] != int_sum[IntW-1]) begin
      int_sat = int_sum[IntW] ? {1'b1, {(IntW-1){1'b0}}} : {1'b0, {(IntW-1){1'b1}}};
    end else begin
      int_sat = int_sum[IntW-1:0];
    end
  end

  // Each multiply step from IL to INT also adds the product of the step before,
  // at the weight of its term: P and the low derivative half carry 2^16, the high
  // integral half 2^24 and the high derivative half 2^40.
  logic signed [AccW-1:0] prod_ext;
  logic signed [AccW-1:0] addend;
  logic                   acc_add;

  assign prod_ext = AccW'(prod);

  always_comb begin
    acc_add = 1'b1;
    unique case (state)
      S_MUL_IL:  addend = prod_ext <<< 16;
      S_MUL_IH:  addend = prod_ext;
      S_MUL_DL:  addend = prod_ext <<< 24;
      S_MUL_DH:  addend = prod_ext <<< 16;
      S_MUL_INT: addend = prod_ext <<< 40;
      default: begin
        addend  = '0;
        acc_add = 1'b0;
      end
    endcase
  end

  // Output stage: magnitude after the absolute value, integer part, limited.
  logic [IntW-1:0] duty_mag;
  logic [7:0]      duty_val;
  logic            out_free;

  assign duty_mag = acc[AccW-1:AccW-IntW];
  assign duty_val = (duty_mag > IntW'(duty_limit)) ? duty_limit : duty_mag[7:0];
  assign out_free = !result_valid || result_ready;

  // Sequencer: next state and the operands for the shared multiplier.
  always_comb begin
    state_next = state;
    mul_op     = '{en: 1'b0, a: '0, b: '0};
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          state_next = S_POS;
        end
      end
      S_POS: begin
        mul_op     = '{en: 1'b1, a: MulAW'(enc_count), b: {1'b0, count_scale}};
        state_next = S_ERR;
      end
      S_ERR: begin
        state_next = is_tick ? S_MUL_P : S_FIN;
      end
      S_MUL_P: begin
        mul_op     = '{en: 1'b1, a: {1'b0, gain_p}, b: err};
        state_next = S_MUL_IL;
      end
      S_MUL_IL: begin
        mul_op     = '{en: 1'b1, a: {1'b0, gain_i}, b: {1'b0, integral_acc[23:0]}};
        state_next = S_MUL_IH;
      end
      S_MUL_IH: begin
        mul_op     = '{en: 1'b1, a: {1'b0, gain_i},
                       b: MulBW'($signed(integral_acc[IntW-1:24]))};
        state_next = S_MUL_DL;
      end
      S_MUL_DL: begin
        mul_op     = '{en: 1'b1, a: {1'b0, gain_d}, b: {1'b0, derivative_term[23:0]}};
        state_next = S_MUL_DH;
      end
      S_MUL_DH: begin
        mul_op     = '{en: 1'b1, a: {1'b0, gain_d},
                       b: MulBW'($signed(derivative_term[IntW-1:24]))};
        state_next = S_MUL_INT;
      end
      S_MUL_INT: begin
        mul_op     = '{en: 1'b1, a: MulAW'(err_sum), b: {1'b0, tick_period}};
        state_next = S_MUL_DER;
      end
      S_MUL_DER: begin
        mul_op     = '{en: 1'b1, a: MulAW'(err_diff), b: {9'd0, tick_rate}};
        state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Persistent controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      enc_count       <= '0;
      integral_acc    <= '0;
      previous_error  <= '0;
      derivative_term <= '0;
    end else begin
      if (state == S_IDLE && item_valid && item.cmd == CMD_EDGE && edge_used) begin
        enc_count <= edge_up ? enc_count + 32'sd1 : enc_count - 32'sd1;
      end
      // The multiplier now holds the integral step of this tick.
      if (state == S_MUL_DER) begin
        integral_acc <= int_sat;
      end
      // The multiplier now holds the new derivative.
      if (state == S_FIN && out_free && is_tick) begin
        derivative_term <= prod[IntW-1:0];
        previous_error  <= err;
      end
    end
  end

  // Working registers of the current beat.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) begin
      is_tick <= (item.cmd == CMD_TICK);
      ref_pos <= item.ref_position;
    end
    if (state == S_ERR) begin
      pos <= pos_sat;
      err <= err_next;
    end
    if (state == S_MUL_P) begin
      acc <= '0;
    end else if (acc_add) begin
      acc <= acc + addend;
    end else if (state == S_MUL_DER) begin
      acc <= acc[AccW-1] ? -acc : acc;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      result.count     <= enc_count;
      result.position  <= pos;
      result.duty      <= is_tick ? duty_val : 8'd0;
      result.direction <= is_tick && (err > 0);
      result.is_tick   <= is_tick;
    end
  end

`ifndef NO_ASSERTIONS
  // An accepted beat always starts with the position multiply.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> state == S_POS)
    else $error("sequencer did not start after an accepted beat");

  // Edge results carry no drive.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.is_tick |-> result.duty == 8'd0 && !result.direction)
    else $error("edge result with nonzero drive");

  // A tick result never exceeds the duty limit.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.is_tick |-> result.duty <= duty_limit)
    else $error("duty above limit");
`endif

endmodule

`default_nettype wire
